// ----- hdl/bvn_pkg.sv -----
// package: constants and types for the bicubic value noise block
package bvn_pkg;

    localparam logic [31:0] YSCALE     = 32'd57;
    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_B = 32'd789221;
    localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] VALUE_ONE  = 32'h40000000;

    // lattice value width (signed q2.30), row result width
    localparam int VW = 32;
    localparam int RW = 40;
    localparam int FW = 48;

    // cycles from accepted point to presented result
    localparam int LATENCY = 16;

    typedef logic signed [VW-1:0] lval_t;
    typedef logic signed [RW-1:0] rval_t;
    typedef logic signed [FW-1:0] fval_t;
    typedef logic [15:0]          frac_t;

endpackage

// ----- hdl/bvn_if.sv -----
// valid/ready channel interfaces for points and noise results
interface bvn_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    modport source (output valid, coord_x, coord_y, input ready);
    modport sink (input valid, coord_x, coord_y, output ready);
endinterface

interface bvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

// ----- hdl/bvn_hash.sv -----
// pipelined lattice hash: four register stages from lattice point to q2.30 value
module bvn_hash
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         lx,
    input  logic [31:0]         ly,
    input  logic [31:0]         seed_term,
    output bvn_pkg::lval_t      value
);
    import bvn_pkg::*;

    logic [31:0] n_reg, nn_reg, n2_reg, h1_reg, h2_reg;
    logic [31:0] n_next;
    lval_t       value_reg;

    assign n_next = lx + ly * YSCALE + seed_term;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= (n_next << HASH_SHIFT) ^ n_next;
            nn_reg    <= n_reg * n_reg;
            n2_reg    <= n_reg;
            h1_reg    <= nn_reg * HASH_MUL_A + HASH_ADD_B;
            h2_reg    <= n2_reg;
            value_reg <= lval_t'(VALUE_ONE - ((h2_reg * h1_reg + HASH_ADD_C) & HASH_MASK));
        end
    end

    assign value = value_reg;
endmodule

// ----- hdl/bvn_cubic.sv -----
// pipelined cubic interpolation, at most one multiply per stage
module bvn_cubic
(
    input  logic                  clk,
    input  logic                  en,
    input  bvn_pkg::rval_t        a,
    input  bvn_pkg::rval_t        b,
    input  bvn_pkg::rval_t        c,
    input  bvn_pkg::rval_t        d,
    input  bvn_pkg::frac_t        t,
    output bvn_pkg::rval_t        y
);
    import bvn_pkg::*;

    fval_t p_reg, q_reg, r_reg, b0_reg;
    frac_t t0_reg;
    fval_t acc1_reg, r1_reg, b1_reg;
    frac_t t1_reg;
    fval_t acc2_reg, r2_reg, b2_reg;
    frac_t t2_reg;
    fval_t acc3_reg, b3_reg;
    fval_t y_reg;
    fval_t ea, eb, ec, ed, p_next;
    logic signed [FW+16:0] m1, m2, m3;

    assign ea = FW'(a);
    assign eb = FW'(b);
    assign ec = FW'(c);
    assign ed = FW'(d);
    assign p_next = (ed - ec) - (ea - eb);
    assign m1 = p_reg * $signed({1'b0, t0_reg});
    assign m2 = acc1_reg * $signed({1'b0, t1_reg});
    assign m3 = acc2_reg * $signed({1'b0, t2_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            q_reg    <= (ea - eb) - p_next;
            r_reg    <= ec - ea;
            b0_reg   <= eb;
            t0_reg   <= t;
            acc1_reg <= FW'(m1 >>> 16) + q_reg;
            r1_reg   <= r_reg;
            b1_reg   <= b0_reg;
            t1_reg   <= t0_reg;
            acc2_reg <= FW'(m2 >>> 16) + r1_reg;
            b2_reg   <= b1_reg;
            t2_reg   <= t1_reg;
            acc3_reg <= FW'(m3 >>> 16);
            b3_reg   <= b2_reg;
            y_reg    <= acc3_reg + b3_reg;
        end
    end

    assign y = RW'(y_reg);
endmodule

// ----- hdl/bicubic_value_noise_2d.sv -----
// top level: bicubic value noise over a 2d lattice, one point per cycle unless the output stalls
// Takes one point per clock and returns one Q8.24 noise value per point, in order,
// through an input register, a 4-stage hash, 5-stage x and y cubic units and an
// output saturation register; the whole pipeline advances while the output
// stage is free or being taken, so back-to-back throughput is one item per cycle. The 16
// lattice hashes run in parallel hash pipelines; the four x cubics run in parallel.
module bicubic_value_noise_2d
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    bvn_in_if.sink            in_ch,
    bvn_out_if.source         out_ch
);
    import bvn_pkg::*;

    logic [31:0]   seed_reg, seed_term_reg;
    logic          en;
    logic [LATENCY-1:0] vld_reg;
    logic [31:0]   bx_reg, by_reg;
    frac_t         fx_reg, fy_reg;
    frac_t         fx_d[0:3];
    frac_t         fy_d[0:8];
    lval_t         hv[0:3][0:3];
    rval_t         rowv[0:3];
    rval_t         fin;
    logic signed [RW-7:0] sh;
    logic signed [31:0] sat;
    logic signed [31:0] res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_term_reg <= seed_reg * YSCALE * YSCALE;
    end

    // the last stage holds unless taken
    assign en = !vld_reg[LATENCY-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx_reg <= {{16{in_ch.coord_x[31]}}, in_ch.coord_x[31:16]};
            by_reg <= {{16{in_ch.coord_y[31]}}, in_ch.coord_y[31:16]};
            fx_reg <= in_ch.coord_x[15:0];
            fy_reg <= in_ch.coord_y[15:0];
            fx_d[0] <= fx_reg;
            fy_d[0] <= fy_reg;
            for (int i = 1; i < 4; i++)
            begin
                fx_d[i] <= fx_d[i-1];
            end
            for (int i = 1; i < 9; i++)
            begin
                fy_d[i] <= fy_d[i-1];
            end
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            bvn_hash u_hash (
                .clk      (clk),
                .en       (en),
                .lx       (bx_reg + 32'(c) - 32'd1),
                .ly       (by_reg + 32'(r) - 32'd1),
                .seed_term(seed_term_reg),
                .value    (hv[r][c])
            );
        end
        bvn_cubic u_xcub (
            .clk(clk),
            .en (en),
            .a  (RW'(hv[r][0])),
            .b  (RW'(hv[r][1])),
            .c  (RW'(hv[r][2])),
            .d  (RW'(hv[r][3])),
            .t  (fx_d[3]),
            .y  (rowv[r])
        );
    end

    bvn_cubic u_ycub (
        .clk(clk),
        .en (en),
        .a  (rowv[0]),
        .b  (rowv[1]),
        .c  (rowv[2]),
        .d  (rowv[3]),
        .t  (fy_d[8]),
        .y  (fin)
    );

    assign sh = fin[RW-1:6];
    always_comb
    begin
        priority if (sh > (RW-6)'(32'sh7fffffff))
            sat = 32'sh7fffffff;
        else if (sh < -(RW-6)'(64'sh80000000))
            sat = 32'sh80000000;
        else
            sat = sh[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sat;
        end
    end

    assign out_ch.valid = vld_reg[LATENCY-1];
    assign out_ch.noise_value = res_reg;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipeline stalled with empty output");
`endif
endmodule

// ----- verif/tb_bicubic_value_noise_2d.sv -----
// testbench: random and directed points checked against a bicubic value noise predictor
`timescale 1ns / 1ps

module tb_bicubic_value_noise_2d;
    import bvn_pkg::*;

    localparam int NUM_PHASES = 5;

    class noise_board;
        int expected_noise[$];
        bit [31:0] seed;
        int mismatches;
        int points_taken;
        int values_checked;

        function new();
            seed = 32'd0;
            mismatches = 0;
            points_taken = 0;
            values_checked = 0;
        endfunction

        function longint lattice_value(bit [31:0] lx, bit [31:0] ly);
            bit [31:0] n;
            bit [31:0] h;
            bit [31:0] seed_mix;
            bit [31:0] y_mix;
            seed_mix = seed * YSCALE;
            seed_mix = seed_mix * YSCALE;
            y_mix = ly * YSCALE;
            n = lx + y_mix + seed_mix;
            n = (n << HASH_SHIFT) ^ n;
            h = n * n;
            h = h * HASH_MUL_A + HASH_ADD_B;
            h = n * h + HASH_ADD_C;
            h = h & HASH_MASK;
            return longint'(VALUE_ONE) - longint'(h);
        endfunction

        function longint cubic(longint a, longint b, longint c, longint d, longint t);
            longint p;
            longint q;
            longint r;
            longint acc;
            p = (d - c) - (a - b);
            q = (a - b) - p;
            r = c - a;
            acc = ((p * t) >>> 16) + q;
            acc = ((acc * t) >>> 16) + r;
            return ((acc * t) >>> 16) + b;
        endfunction

        function int noise_at(bit [31:0] ux, bit [31:0] uy);
            bit [31:0] bx;
            bit [31:0] by;
            bit [31:0] ly;
            longint fx;
            longint fy;
            longint row [4];
            longint res;
            bx = {{16{ux[31]}}, ux[31:16]};
            by = {{16{uy[31]}}, uy[31:16]};
            fx = longint'(ux[15:0]);
            fy = longint'(uy[15:0]);
            for (int r = 0; r < 4; r++)
            begin
                ly = by + r - 1;
                row[r] = cubic(lattice_value(bx - 1, ly), lattice_value(bx, ly),
                               lattice_value(bx + 1, ly), lattice_value(bx + 2, ly), fx);
            end
            res = cubic(row[0], row[1], row[2], row[3], fy) >>> 6;
            if (res > 64'sd2147483647)
                res = 64'sd2147483647;
            if (res < -64'sd2147483648)
                res = -64'sd2147483648;
            return int'(res);
        endfunction

        function void note_point(bit [31:0] ux, bit [31:0] uy);
            expected_noise.push_back(noise_at(ux, uy));
            points_taken++;
        endfunction

        function void check_noise(int actual);
            int want;
            if (expected_noise.size() == 0)
            begin
                $error("noise_value: unexpected item, actual %0d", actual);
                mismatches++;
                return;
            end
            want = expected_noise.pop_front();
            values_checked++;
            if (want != actual)
            begin
                $error("noise_value expected %0d actual %0d", want, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;
    int send_idle_pct;
    int recv_stall_pct;
    noise_board board;

    bvn_in_if in_ch ();
    bvn_out_if out_ch ();

    bicubic_value_noise_2d dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_noise(out_ch.noise_value);
    end

    task automatic send_point(bit [31:0] x, bit [31:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.coord_x <= x;
        in_ch.coord_y <= y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_point(x, y);
        @(negedge clk);
    endtask

    task automatic drain_and_write_seed(bit [31:0] seed);
        in_ch.valid <= 1'b0;
        while (board.expected_noise.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= seed;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.seed = seed;
        @(negedge clk);
    endtask

    task automatic send_random_point();
        bit [31:0] x;
        bit [31:0] y;
        int kind;
        kind = $urandom_range(3);
        x = $urandom;
        y = $urandom;
        if (kind == 1)
        begin
            x = {{16{x[31]}}, x[15:0]} >>> $urandom_range(12);
            y = {{16{y[31]}}, y[15:0]} >>> $urandom_range(12);
        end
        else if (kind == 2)
        begin
            x[15:0] = ($urandom_range(1)) ? 16'h0000 : 16'hffff;
            y[15:0] = ($urandom_range(1)) ? 16'h0000 : 16'hffff;
        end
        send_point(x, y);
    endtask

    initial
    begin
        bit [31:0] seeds [NUM_PHASES];
        int idle_set [NUM_PHASES];
        int stall_set [NUM_PHASES];
        bit [31:0] edge_coords [8];

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.coord_x = 32'd0;
        in_ch.coord_y = 32'd0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        board = new();

        seeds = '{32'd0, 32'hffffffff, 32'd1, 32'h80000000, $urandom};
        idle_set = '{0, 49, 0, 34, 0};
        stall_set = '{0, 0, 49, 34, 0};
        edge_coords = '{32'h00000000, 32'h80000000, 32'h7fffffff, 32'hffff0000,
                        32'hffffffff, 32'h0000ffff, 32'h7fff0000, 32'h8000ffff};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_and_write_seed(seeds[ph]);
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            if (ph == 0 || ph == 3)
            begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        send_point(edge_coords[i * 2], edge_coords[j * 2 + 1]);
                send_point(32'hfffe0000, 32'hfff00000);
                send_point(32'h00018000, 32'h00004000);
            end
            repeat (190)
                send_random_point();
        end

        in_ch.valid <= 1'b0;
        while (board.expected_noise.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("ran %0d points over %0d seeds incl. lattice wrap and exact negative integers",
                 board.points_taken, NUM_PHASES);
        $display("checked %0d noise values under four handshake idling mixes",
                 board.values_checked);
        if (board.mismatches == 0 && board.expected_noise.size() == 0)
            $display("bicubic_value_noise_2d regression: pass");
        else
            $display("bicubic_value_noise_2d regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("bicubic_value_noise_2d regression: fail");
        $finish;
    end

endmodule
